// ===== sv/tcc_pkg.sv =====
// Shared types and constants for the triangle circumcenter pipeline.
// Depends on nothing; the geometry, divider and top-level files refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

    // Coordinate width and the widths that grow from it through the datapath.
    localparam int COORD_BITS = 32;
    localparam int DW   = COORD_BITS + 1;   // vertex difference, signed
    localparam int PW   = 2 * DW;           // product of two differences, signed
    localparam int AW   = PW + 1;           // doubled area, signed
    localparam int LW   = 2 * DW;           // squared edge length, unsigned
    localparam int HW   = LW - DW;          // upper part of a squared length
    localparam int PPW  = DW + HW + 1;      // partial product, signed
    localparam int XW   = LW + DW;          // full product, signed
    localparam int NW   = XW + 1;           // centre numerator, signed
    localparam int AREA_BITS = 64;          // width of the area result

    // Quotient range: magnitudes above 2^CAP_LOG are clamped.
    localparam int CAP_LOG = 34;
    localparam int QB      = CAP_LOG + 2;   // quotient bits resolved
    localparam int CW      = NW + QB;       // divider compare width
    localparam int SW      = CAP_LOG + 3;   // width of base plus offset

    // Pipeline depths.
    localparam int GEO_LAT = 7;
    localparam int DIV_LAT = QB + 2;
    localparam int LAT     = GEO_LAT + DIV_LAT;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_a_x;
        logic signed [COORD_BITS-1:0] vertex_a_y;
        logic signed [COORD_BITS-1:0] vertex_b_x;
        logic signed [COORD_BITS-1:0] vertex_b_y;
        logic signed [COORD_BITS-1:0] vertex_c_x;
        logic signed [COORD_BITS-1:0] vertex_c_y;
    } t_tri_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [AREA_BITS-1:0]  twice_area;
        logic                         status;
    } t_tri_res;

    // One coordinate's division job.
    typedef struct packed {
        logic [NW-1:0]                num;   // |n| + D
        logic [AW-1:0]                den;   // 2D
        logic                         neg;   // sign of n
        logic signed [COORD_BITS-1:0] base;  // vertex a coordinate
        logic                         zero;  // force the centre to zero
    } t_div_op;

    // Side data that bypasses the dividers.
    typedef struct packed {
        logic signed [AREA_BITS-1:0] area;
        logic                        bad;
    } t_side;

endpackage

`default_nettype wire

// ===== sv/tcc_stream_if.sv =====
// Valid/ready stream interface carrying one request of a given payload type.
// Payload types come from tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tcc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/tcc_geom.sv =====
// Geometry front end: differences, area, squared lengths, centre numerators.
// Seven register stages; uses tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcc_geom (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire tcc_pkg::t_tri_in i_tri,
    output tcc_pkg::t_div_op      o_x,
    output tcc_pkg::t_div_op      o_y,
    output tcc_pkg::t_side        o_side
);

    localparam int CB  = tcc_pkg::COORD_BITS;
    localparam int DW  = tcc_pkg::DW;
    localparam int PW  = tcc_pkg::PW;
    localparam int AW  = tcc_pkg::AW;
    localparam int LW  = tcc_pkg::LW;
    localparam int PPW = tcc_pkg::PPW;
    localparam int XW  = tcc_pkg::XW;
    localparam int NW  = tcc_pkg::NW;
    localparam int ABW = tcc_pkg::AREA_BITS;

    // Unsigned part times signed difference.
    function automatic logic signed [PPW-1:0] pmul(input logic [DW-1:0] part,
                                                   input logic signed [DW-1:0] m);
        logic signed [PPW-1:0] a;
        logic signed [PPW-1:0] b;
        a = $signed({1'b0, part});
        b = m;
        pmul = a * b;
    endfunction

    // Joins the upper and lower partial products of one full product.
    function automatic logic signed [XW-1:0] pjoin(input logic signed [PPW-1:0] hi,
                                                   input logic signed [PPW-1:0] lo);
        logic signed [XW-1:0] h;
        logic signed [XW-1:0] l;
        h = hi;
        l = lo;
        pjoin = (h <<< DW) + l;
    endfunction

    // Stage 1: edge vectors relative to vertex a.
    logic signed [CB-1:0] r1_ax, r1_ay;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_ex, r1_ey;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax <= i_tri.vertex_a_x;
            r1_ay <= i_tri.vertex_a_y;
            r1_dx <= DW'(i_tri.vertex_b_x) - DW'(i_tri.vertex_a_x);
            r1_dy <= DW'(i_tri.vertex_b_y) - DW'(i_tri.vertex_a_y);
            r1_ex <= DW'(i_tri.vertex_c_x) - DW'(i_tri.vertex_a_x);
            r1_ey <= DW'(i_tri.vertex_c_y) - DW'(i_tri.vertex_a_y);
        end
    end

    // Stage 2: cross terms and squares.
    logic signed [CB-1:0] r2_ax, r2_ay;
    logic signed [DW-1:0] r2_dx, r2_dy, r2_ex, r2_ey;
    logic signed [PW-1:0] r2_dxey, r2_dyex, r2_dxx, r2_dyy, r2_exx, r2_eyy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_ex   <= r1_ex;
            r2_ey   <= r1_ey;
            r2_dxey <= r1_dx * r1_ey;
            r2_dyex <= r1_dy * r1_ex;
            r2_dxx  <= r1_dx * r1_dx;
            r2_dyy  <= r1_dy * r1_dy;
            r2_exx  <= r1_ex * r1_ex;
            r2_eyy  <= r1_ey * r1_ey;
        end
    end

    // Stage 3: doubled area and squared edge lengths.
    logic signed [CB-1:0] r3_ax, r3_ay;
    logic signed [DW-1:0] r3_dx, r3_dy, r3_ex, r3_ey;
    logic signed [AW-1:0] r3_area;
    logic        [LW-1:0] r3_ld, r3_le;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_ex   <= r2_ex;
            r3_ey   <= r2_ey;
            r3_area <= AW'(r2_dxey) - AW'(r2_dyex);
            r3_ld   <= LW'(r2_dxx + r2_dyy);
            r3_le   <= LW'(r2_exx + r2_eyy);
        end
    end

    // Area saturation and the sign check for inverted or degenerate triangles.
    logic                  w_area_fits;
    logic signed [ABW-1:0] w_area64;
    logic                  w_bad;

    always_comb begin
        w_area_fits = (&r3_area[AW-1:ABW-1]) || !(|r3_area[AW-1:ABW-1]);
        if (w_area_fits) begin
            w_area64 = r3_area[ABW-1:0];
        end else if (r3_area[AW-1]) begin
            w_area64 = {1'b1, {(ABW-1){1'b0}}};
        end else begin
            w_area64 = {1'b0, {(ABW-1){1'b1}}};
        end
        w_bad = r3_area[AW-1] || (r3_area == '0);
    end

    // Stage 4: partial products of the numerator terms.
    logic signed [CB-1:0]  r4_ax, r4_ay;
    logic signed [AW-1:0]  r4_area;
    logic signed [ABW-1:0] r4_area64;
    logic                  r4_bad;
    logic signed [PPW-1:0] r4_ldey_h, r4_ldey_l, r4_ledy_h, r4_ledy_l;
    logic signed [PPW-1:0] r4_ledx_h, r4_ledx_l, r4_ldex_h, r4_ldex_l;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ax     <= r3_ax;
            r4_ay     <= r3_ay;
            r4_area   <= r3_area;
            r4_area64 <= w_area64;
            r4_bad    <= w_bad;
            r4_ldey_h <= pmul(r3_ld[LW-1:DW], r3_ey);
            r4_ldey_l <= pmul(r3_ld[DW-1:0],  r3_ey);
            r4_ledy_h <= pmul(r3_le[LW-1:DW], r3_dy);
            r4_ledy_l <= pmul(r3_le[DW-1:0],  r3_dy);
            r4_ledx_h <= pmul(r3_le[LW-1:DW], r3_dx);
            r4_ledx_l <= pmul(r3_le[DW-1:0],  r3_dx);
            r4_ldex_h <= pmul(r3_ld[LW-1:DW], r3_ex);
            r4_ldex_l <= pmul(r3_ld[DW-1:0],  r3_ex);
        end
    end

    // Stage 5: full products.
    logic signed [CB-1:0]  r5_ax, r5_ay;
    logic signed [AW-1:0]  r5_area;
    logic signed [ABW-1:0] r5_area64;
    logic                  r5_bad;
    logic signed [XW-1:0]  r5_ldey, r5_ledy, r5_ledx, r5_ldex;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ax     <= r4_ax;
            r5_ay     <= r4_ay;
            r5_area   <= r4_area;
            r5_area64 <= r4_area64;
            r5_bad    <= r4_bad;
            r5_ldey   <= pjoin(r4_ldey_h, r4_ldey_l);
            r5_ledy   <= pjoin(r4_ledy_h, r4_ledy_l);
            r5_ledx   <= pjoin(r4_ledx_h, r4_ledx_l);
            r5_ldex   <= pjoin(r4_ldex_h, r4_ldex_l);
        end
    end

    // Stage 6: centre numerators.
    logic signed [CB-1:0]  r6_ax, r6_ay;
    logic signed [AW-1:0]  r6_area;
    logic signed [ABW-1:0] r6_area64;
    logic                  r6_bad;
    logic signed [NW-1:0]  r6_nx, r6_ny;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_ax     <= r5_ax;
            r6_ay     <= r5_ay;
            r6_area   <= r5_area;
            r6_area64 <= r5_area64;
            r6_bad    <= r5_bad;
            r6_nx     <= NW'(r5_ldey) - NW'(r5_ledy);
            r6_ny     <= NW'(r5_ledx) - NW'(r5_ldex);
        end
    end

    // Stage 7: rounding offset folded into the magnitude, divisor doubled.
    logic signed [NW-1:0] w_area_n;
    logic        [AW-1:0] w_den;

    always_comb begin
        w_area_n = NW'(r6_area);
        w_den    = {r6_area[AW-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x.num  <= r6_nx[NW-1] ? NW'(w_area_n - r6_nx) : NW'(w_area_n + r6_nx);
            o_x.den  <= w_den;
            o_x.neg  <= r6_nx[NW-1];
            o_x.base <= r6_ax;
            o_x.zero <= r6_bad;
            o_y.num  <= r6_ny[NW-1] ? NW'(w_area_n - r6_ny) : NW'(w_area_n + r6_ny);
            o_y.den  <= w_den;
            o_y.neg  <= r6_ny[NW-1];
            o_y.base <= r6_ay;
            o_y.zero <= r6_bad;
            o_side.area <= r6_area64;
            o_side.bad  <= r6_bad;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcc_div.sv =====
// Pipelined restoring divider for one centre coordinate, one quotient bit per
// stage, followed by clamping, the add of the vertex and saturation. Uses tcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcc_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire tcc_pkg::t_div_op                 i_op,
    output logic signed [tcc_pkg::COORD_BITS-1:0] o_coord
);

    localparam int CB      = tcc_pkg::COORD_BITS;
    localparam int NW      = tcc_pkg::NW;
    localparam int AW      = tcc_pkg::AW;
    localparam int QB      = tcc_pkg::QB;
    localparam int CW      = tcc_pkg::CW;
    localparam int SW      = tcc_pkg::SW;
    localparam int CAP_LOG = tcc_pkg::CAP_LOG;

    logic [NW-1:0]        r_rem  [0:QB];
    logic [AW-1:0]        r_den  [0:QB];
    logic [QB-1:0]        r_q    [0:QB];
    logic                 r_ovf  [0:QB];
    logic                 r_neg  [0:QB];
    logic                 r_zero [0:QB];
    logic signed [CB-1:0] r_base [0:QB];

    // Entry stage: quotients of 2^QB or more are flagged and clamped later.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_op.num;
            r_den[0]  <= i_op.den;
            r_q[0]    <= '0;
            r_ovf[0]  <= CW'(i_op.num) >= (CW'(i_op.den) << QB);
            r_neg[0]  <= i_op.neg;
            r_zero[0] <= i_op.zero;
            r_base[0] <= i_op.base;
        end
    end

    // One trial subtraction per stage, most significant quotient bit first.
    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int J = QB - 1 - k;
        logic [CW-1:0] w_sh;
        logic          w_ge;

        always_comb begin
            w_sh = CW'(r_den[k]) << J;
            w_ge = CW'(r_rem[k]) >= w_sh;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? NW'(CW'(r_rem[k]) - w_sh) : r_rem[k];
                r_den[k+1]  <= r_den[k];
                r_q[k+1]    <= r_q[k] | (QB'(w_ge) << J);
                r_ovf[k+1]  <= r_ovf[k];
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
                r_base[k+1] <= r_base[k];
            end
        end
    end

    // Clamp the magnitude, apply the sign, add the vertex and saturate.
    logic [CAP_LOG:0]     w_mag;
    logic signed [SW-1:0] w_off;
    logic signed [SW-1:0] w_sum;
    logic                 w_fits;
    logic signed [CB-1:0] n_coord;

    always_comb begin
        if (r_ovf[QB] || (r_q[QB] > (QB'(1) << CAP_LOG))) begin
            w_mag = (CAP_LOG + 1)'(1) << CAP_LOG;
        end else begin
            w_mag = r_q[QB][CAP_LOG:0];
        end
        w_off = $signed(SW'(w_mag));
        if (r_neg[QB]) begin
            w_off = -w_off;
        end
        w_sum  = SW'(r_base[QB]) + w_off;
        w_fits = (&w_sum[SW-1:CB-1]) || !(|w_sum[SW-1:CB-1]);
        if (r_zero[QB]) begin
            n_coord = '0;
        end else if (w_fits) begin
            n_coord = w_sum[CB-1:0];
        end else if (w_sum[SW-1]) begin
            n_coord = {1'b1, {(CB-1){1'b0}}};
        end else begin
            n_coord = {1'b0, {(CB-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_coord <= n_coord;
        end
    end

endmodule

`default_nettype wire

// ===== sv/triangle_circumcenter.sv =====
// Top level of the triangle circumcenter pipeline: front end, two dividers,
// side-data delay line and valid tracking. Uses tcc_pkg, tcc_stream_if, tcc_geom, tcc_div.
//
//   Port    Dir  Payload             Role
//   i_tri   in   tcc_pkg::t_tri_in   three vertices, one request per triangle
//   o_res   out  tcc_pkg::t_tri_res  centre, doubled area, status
//
// Accepts one triangle per clock while finished results are taken; each result passes the front end,
// then the entry stage, the 36 quotient-bit stages and the output register of the centre dividers.
// Reset clears only the valid bits of the pipeline.
// While a finished result is not taken the whole pipeline holds; the input is
// ready in every other cycle, including the one in which the result leaves.
`timescale 1ns / 1ps
`default_nettype none

module triangle_circumcenter (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tcc_stream_if.sink   i_tri,
    tcc_stream_if.source o_res
);

    localparam int LAT     = tcc_pkg::LAT;
    localparam int DIV_LAT = tcc_pkg::DIV_LAT;

    logic                w_adv;
    logic                w_in_acc;
    logic [LAT-1:0]      r_vld;
    tcc_pkg::t_div_op    w_op_x, w_op_y;
    tcc_pkg::t_side      w_side;
    tcc_pkg::t_side      r_side [0:DIV_LAT-1];
    logic signed [tcc_pkg::COORD_BITS-1:0] w_cx, w_cy;

    // The pipeline moves unless a finished result is held up.
    assign w_adv       = !r_vld[LAT-1] || o_res.ready;
    assign w_in_acc    = i_tri.valid && w_adv;
    assign i_tri.ready = w_adv;

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], w_in_acc};
        end
    end

    tcc_geom u_geom (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_tri  (i_tri.data),
        .o_x    (w_op_x),
        .o_y    (w_op_y),
        .o_side (w_side)
    );

    tcc_div u_div_x (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_op    (w_op_x),
        .o_coord (w_cx)
    );

    tcc_div u_div_y (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_op    (w_op_y),
        .o_coord (w_cy)
    );

    // Area and status wait alongside the dividers.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= w_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign o_res.valid = r_vld[LAT-1];
    assign o_res.data  = '{center_x:   w_cx,
                           center_y:   w_cy,
                           twice_area: r_side[DIV_LAT-1].area,
                           status:     r_side[DIV_LAT-1].bad};

    // A flagged triangle always carries a zero centre.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.status |->
            (o_res.data.center_x == '0) && (o_res.data.center_y == '0))
        else $error("flagged triangle with nonzero centre");

    // A triangle passed as valid has a strictly positive area.
    a_good_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.status |->
            !o_res.data.twice_area[tcc_pkg::AREA_BITS-1] &&
            (o_res.data.twice_area != '0))
        else $error("valid triangle with non-positive area");

    // An accepted request enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tri.valid && i_tri.ready |=> r_vld[0])
        else $error("accepted request lost at entry");

    // A stall freezes every valid bit.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
